### sv/look_elevator_request_scheduler_top_macros.svh
// Assertion macros shared by the LOOK request scheduler RTL.
// Bodies compile away when SYNTHESIS is defined; no other dependencies.
`ifndef LOOK_ELEVATOR_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define LOOK_ELEVATOR_REQUEST_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define LERS_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lers: property violated");
// Next-cycle implication, disabled while reset is low.
`define LERS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lers: property violated");
`else
`define LERS_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define LERS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/lers_pkg.sv
// Shared types and constants for the LOOK request scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package lers_pkg;

  localparam int unsigned SECTOR_FIELD_W = 48;
  localparam int unsigned LENGTH_W       = 16;
  localparam int unsigned TAG_W          = 8;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned COUNT_FIELD_W  = 6;

  localparam int unsigned IN_SEC_LSB     = 0;
  localparam int unsigned IN_LEN_LSB     = IN_SEC_LSB + SECTOR_FIELD_W;
  localparam int unsigned IN_TAG_LSB     = IN_LEN_LSB + LENGTH_W;
  localparam int unsigned IN_TDATA_W     = IN_TAG_LSB + TAG_W;

  localparam int unsigned OUT_TDATA_W    = 80;

  localparam logic ACT_ADD      = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_ADD_START,
    DP_ADD_CMP,
    DP_ADD_PUT,
    DP_DSP_START,
    DP_DSP_SCAN,
    DP_DSP_HEAD,
    DP_DSP_SHIFT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    load_in;
    logic    load_out;
    status_t status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic add_gt;
    logic add_last;
    logic scan_stop;
    logic head_last;
    logic shift_last;
  } dp_stat_t;

endpackage

### sv/lers_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lers_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/lers_ctrl.sv
// Sequencing controller for the LOOK request scheduler: handshakes and phases.
// Depends on lers_pkg and the assertion macro header.
`include "look_elevator_request_scheduler_top_macros.svh"

module lers_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_action,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output lers_pkg::ctrl_cmd_t  cmd,
  input  lers_pkg::dp_stat_t   stat
);

  import lers_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_START,
    S_ADD_CMP,
    S_ADD_PUT,
    S_DSP_START,
    S_DSP_SCAN,
    S_DSP_HEAD,
    S_DSP_SHIFT,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = DP_IDLE;
    cmd.load_in   = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.status    = st_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          if (in_action == ACT_DISPATCH) begin
            if (stat.empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              st_nxt    = ST_DISPATCHED;
              state_nxt = S_DSP_START;
            end
          end else begin
            if (stat.full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              st_nxt    = ST_ADDED;
              state_nxt = S_ADD_START;
            end
          end
        end
      end
      S_ADD_START: begin
        cmd.op    = DP_ADD_START;
        state_nxt = stat.empty ? S_ADD_PUT : S_ADD_CMP;
      end
      S_ADD_CMP: begin
        cmd.op = DP_ADD_CMP;
        if (stat.add_gt) begin
          if (stat.add_last) begin
            state_nxt = S_ADD_PUT;
          end
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_ADD_PUT: begin
        cmd.op    = DP_ADD_PUT;
        state_nxt = S_RESP;
      end
      S_DSP_START: begin
        cmd.op    = DP_DSP_START;
        state_nxt = S_DSP_SCAN;
      end
      S_DSP_SCAN: begin
        cmd.op = DP_DSP_SCAN;
        if (stat.scan_stop) begin
          state_nxt = S_DSP_HEAD;
        end
      end
      S_DSP_HEAD: begin
        cmd.op    = DP_DSP_HEAD;
        state_nxt = stat.head_last ? S_RESP : S_DSP_SHIFT;
      end
      S_DSP_SHIFT: begin
        cmd.op = DP_DSP_SHIFT;
        if (stat.shift_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_ADDED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LERS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_tvalid && in_tready, state_r != S_IDLE)
  `LERS_ASSERT_NEXT(a_resp_drains, clk, rst_n, (state_r == S_RESP) && out_tready, out_valid_r && (state_r == S_IDLE))

endmodule

### sv/lers_dpath.sv
// Datapath for the LOOK request scheduler: sorted request RAM, head, direction,
// pointer and result register. Depends on lers_pkg, lers_ram and the macro header.
`include "look_elevator_request_scheduler_top_macros.svh"

module lers_dpath #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned SECTOR_BITS = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [lers_pkg::IN_TDATA_W-1:0]        in_tdata,
  input  lers_pkg::ctrl_cmd_t                    cmd,
  output lers_pkg::dp_stat_t                     stat,
  output logic [lers_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [lers_pkg::STATUS_W-1:0]          out_tuser
);

  import lers_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = SECTOR_BITS + LENGTH_W + TAG_W;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE       = CW'(1);
  localparam logic [CW-1:0] TWO       = CW'(2);

  typedef struct packed {
    logic [TAG_W-1:0]       tag;
    logic [LENGTH_W-1:0]    len;
    logic [SECTOR_BITS-1:0] sec;
  } entry_t;

  entry_t                 new_r, sel_r, sel_nxt, rd_ent, wr_ent;
  logic [CW-1:0]          count_r, count_nxt, ptr_r, ptr_nxt;
  logic [CW-1:0]          count_m1, scan_step, wr_ptr, rd_ptr;
  logic [SECTOR_BITS-1:0] head_r, head_nxt;
  logic [SECTOR_BITS:0]   head_sum;
  logic                   fwd_r, fwd_nxt;
  logic                   hit, scan_last;
  logic                   wr_en, rd_en;
  logic [EW-1:0]          rd_data;

  status_t                   out_status_r;
  logic [SECTOR_FIELD_W-1:0] out_sec_r;
  logic [LENGTH_W-1:0]       out_len_r;
  logic [TAG_W-1:0]          out_tag_r;
  logic                      out_fwd_r;
  logic [COUNT_FIELD_W-1:0]  out_cnt_r;

  lers_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr[AW-1:0]),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_ent    = rd_data;
  assign count_m1  = count_r - ONE;
  assign scan_step = fwd_r ? (ptr_r + ONE) : (ptr_r - ONE);
  assign hit       = fwd_r ? (rd_ent.sec > head_r) : (rd_ent.sec < head_r);
  assign scan_last = fwd_r ? (ptr_r == count_m1) : (ptr_r == '0);
  assign head_sum  = {1'b0, sel_r.sec} + (SECTOR_BITS + 1)'(sel_r.len);

  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r == DEPTH_CNT);
  assign stat.add_gt     = (rd_ent.sec > new_r.sec);
  assign stat.add_last   = (ptr_r == ONE);
  assign stat.scan_stop  = hit || scan_last;
  assign stat.head_last  = (ptr_r == count_m1);
  assign stat.shift_last = ((ptr_r + ONE) == count_m1);

  always_comb begin
    ptr_nxt   = ptr_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    fwd_nxt   = fwd_r;
    sel_nxt   = sel_r;
    wr_en     = 1'b0;
    wr_ptr    = ptr_r;
    wr_ent    = new_r;
    rd_en     = 1'b0;
    rd_ptr    = ptr_r;

    unique case (cmd.op)
      DP_IDLE: begin
      end
      DP_ADD_START: begin
        // walk down from the top slot, opening a gap for the new request
        ptr_nxt = count_r;
        if (!stat.empty) begin
          rd_en  = 1'b1;
          rd_ptr = count_m1;
        end
      end
      DP_ADD_CMP: begin
        wr_en = 1'b1;
        if (stat.add_gt) begin
          wr_ent  = rd_ent;
          ptr_nxt = ptr_r - ONE;
          if (!stat.add_last) begin
            rd_en  = 1'b1;
            rd_ptr = ptr_r - TWO;
          end
        end else begin
          count_nxt = count_r + ONE;
        end
      end
      DP_ADD_PUT: begin
        wr_en     = 1'b1;
        count_nxt = count_r + ONE;
      end
      DP_DSP_START: begin
        ptr_nxt = fwd_r ? '0 : count_m1;
        rd_en   = 1'b1;
        rd_ptr  = fwd_r ? '0 : count_m1;
      end
      DP_DSP_SCAN: begin
        // last read entry is the pick when the scan runs out: turn then
        sel_nxt = rd_ent;
        if (stat.scan_stop) begin
          if (!hit && (count_r != ONE)) begin
            fwd_nxt = !fwd_r;
          end
        end else begin
          ptr_nxt = scan_step;
          rd_en   = 1'b1;
          rd_ptr  = scan_step;
        end
      end
      DP_DSP_HEAD: begin
        head_nxt = head_sum[SECTOR_BITS] ? '1 : head_sum[SECTOR_BITS-1:0];
        if (stat.head_last) begin
          count_nxt = count_m1;
        end else begin
          rd_en  = 1'b1;
          rd_ptr = ptr_r + ONE;
        end
      end
      DP_DSP_SHIFT: begin
        // close the gap left by the dispatched entry
        wr_en   = 1'b1;
        wr_ent  = rd_ent;
        ptr_nxt = ptr_r + ONE;
        if (stat.shift_last) begin
          count_nxt = count_m1;
        end else begin
          rd_en  = 1'b1;
          rd_ptr = ptr_r + TWO;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      fwd_r   <= 1'b1;
      ptr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      fwd_r   <= fwd_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    if (cmd.load_in) begin
      new_r.sec <= SECTOR_BITS'(in_tdata[IN_SEC_LSB +: SECTOR_FIELD_W]);
      new_r.len <= in_tdata[IN_LEN_LSB +: LENGTH_W];
      new_r.tag <= in_tdata[IN_TAG_LSB +: TAG_W];
    end
    if (cmd.load_out) begin
      out_status_r <= cmd.status;
      out_fwd_r    <= fwd_r;
      out_cnt_r    <= COUNT_FIELD_W'(count_r);
      if (cmd.status == ST_DISPATCHED) begin
        out_sec_r <= SECTOR_FIELD_W'(sel_r.sec);
        out_len_r <= sel_r.len;
        out_tag_r <= sel_r.tag;
      end else begin
        out_sec_r <= '0;
        out_len_r <= '0;
        out_tag_r <= '0;
      end
    end
  end

  assign out_tuser = out_status_r;
  assign out_tdata = {1'b0, out_cnt_r, out_fwd_r, out_tag_r, out_len_r, out_sec_r};

  `LERS_ASSERT_HOLDS(a_count_range, clk, rst_n, 1'b1, count_r <= DEPTH_CNT)
  `LERS_ASSERT_HOLDS(a_write_in_store, clk, rst_n, wr_en, wr_ptr <= count_r)
  `LERS_ASSERT_NEXT(a_turn_in_scan_only, clk, rst_n, cmd.op != DP_DSP_SCAN, $stable(fwd_r))

endmodule

### sv/look_elevator_request_scheduler_top.sv
// LOOK request scheduler, top level. One transaction in, one result out.
// Results wait for a free result register. An add walks the store down from the top
// to open a gap; a dispatch scans for the pick, then compacts the store through the
// one-read one-write store RAM; empty/full do neither. One item at a time: the next
// is taken in the cycle after the result loads. Reset (rst_n low, synchronous): count
// and head to zero, direction forward; store is not cleared and needs no clearing pass.
module look_elevator_request_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned SECTOR_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [47:0] req_sector, [63:48] req_length, [71:64] req_tag
  input  logic [lers_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] action: 0 add, 1 dispatch
  input  logic                               in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [47:0] out_sector, [63:48] out_length, [71:64] out_tag,
  // [72] sweep_forward, [78:73] pending_count, [79] zero
  output logic [lers_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [1:0] status
  output logic [lers_pkg::STATUS_W-1:0]      out_tuser
);

  import lers_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller: accept a transaction, sequence the datapath, park the result.
  lers_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Datapath: sorted store, head position, sweep direction, result register.
  lers_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

### tb/look_elevator_request_scheduler_checker.sv
`timescale 1ns / 1ps
// Checker for the LOOK request scheduler: watches both stream channels, keeps
// its own copy of the request store, head and sweep direction, and compares results.
// Depends on lers_pkg for field widths, action codes and status codes.
module look_elevator_request_scheduler_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [lers_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [lers_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [lers_pkg::STATUS_W-1:0]    out_tuser,
  output int                               mismatch_count,
  output int                               results_owed,
  output int                               full_hits,
  output int                               empty_hits
);
  import lers_pkg::*;

  localparam int STORE_DEPTH = 32;

  typedef struct packed {
    status_t                   status;
    logic [SECTOR_FIELD_W-1:0] sector;
    logic [LENGTH_W-1:0]       length;
    logic [TAG_W-1:0]          tag;
    logic                      fwd;
    logic [COUNT_FIELD_W-1:0]  count;
  } sched_result_t;

  logic [SECTOR_FIELD_W-1:0] pend_sector [STORE_DEPTH];
  logic [LENGTH_W-1:0]       pend_length [STORE_DEPTH];
  logic [TAG_W-1:0]          pend_tag    [STORE_DEPTH];
  int                        pend_count;
  logic [SECTOR_FIELD_W-1:0] head_pos;
  logic                      sweep_fwd;
  sched_result_t             dispatch_q [$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
    full_hits      = 0;
    empty_hits     = 0;
  end

  task automatic flag_field(input string field, input logic [63:0] got,
                            input logic [63:0] want);
    $display("%0t scheduler check: %s got %0h, want %0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Apply one request to the shadow store and return the result it must produce.
  task automatic schedule_request(input logic act, input logic [SECTOR_FIELD_W-1:0] sec,
                                  input logic [LENGTH_W-1:0] len,
                                  input logic [TAG_W-1:0] tag, output sched_result_t r);
    int                      pos;
    int                      i;
    int                      pick;
    logic                    found;
    logic [SECTOR_FIELD_W:0] sum;
    r = '0;
    if (act == ACT_ADD) begin
      if (pend_count >= STORE_DEPTH) begin
        r.status = ST_FULL;
        full_hits++;
      end else begin
        // insert after any entries holding the same sector
        pos = 0;
        while (pos < pend_count && pend_sector[pos] <= sec) pos++;
        for (i = pend_count; i > pos; i--) begin
          pend_sector[i] = pend_sector[i-1];
          pend_length[i] = pend_length[i-1];
          pend_tag[i]    = pend_tag[i-1];
        end
        pend_sector[pos] = sec;
        pend_length[pos] = len;
        pend_tag[pos]    = tag;
        pend_count++;
        r.status = ST_ADDED;
      end
    end else if (pend_count == 0) begin
      r.status = ST_EMPTY;
      empty_hits++;
    end else begin
      pick  = 0;
      found = 1'b0;
      if (pend_count == 1) begin
        found = 1'b1;
      end else if (sweep_fwd) begin
        for (i = 0; i < pend_count && !found; i++)
          if (pend_sector[i] > head_pos) begin
            pick  = i;
            found = 1'b1;
          end
        if (!found) begin
          sweep_fwd = 1'b0;
          pick      = pend_count - 1;
        end
      end else begin
        for (i = pend_count - 1; i >= 0 && !found; i--)
          if (pend_sector[i] < head_pos) begin
            pick  = i;
            found = 1'b1;
          end
        if (!found) begin
          sweep_fwd = 1'b1;
          pick      = 0;
        end
      end
      r.status = ST_DISPATCHED;
      r.sector = pend_sector[pick];
      r.length = pend_length[pick];
      r.tag    = pend_tag[pick];
      // head saturates at the top sector
      sum      = {1'b0, pend_sector[pick]} + (SECTOR_FIELD_W + 1)'(pend_length[pick]);
      head_pos = sum[SECTOR_FIELD_W] ? '1 : sum[SECTOR_FIELD_W-1:0];
      for (i = pick; i + 1 < pend_count; i++) begin
        pend_sector[i] = pend_sector[i+1];
        pend_length[i] = pend_length[i+1];
        pend_tag[i]    = pend_tag[i+1];
      end
      pend_count--;
    end
    r.fwd   = sweep_fwd;
    r.count = pend_count[COUNT_FIELD_W-1:0];
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      pend_count = 0;
      head_pos   = '0;
      sweep_fwd  = 1'b1;
      dispatch_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        schedule_request(in_tuser, in_tdata[IN_SEC_LSB +: SECTOR_FIELD_W],
                         in_tdata[IN_LEN_LSB +: LENGTH_W], in_tdata[IN_TAG_LSB +: TAG_W],
                         want);
        dispatch_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (dispatch_q.size() == 0) begin
          flag_field("unexpected result", {out_tuser, out_tdata[61:0]}, 64'h0);
        end else begin
          want = dispatch_q.pop_front();
          if (out_tuser !== want.status)
            flag_field("status", 64'(out_tuser), 64'(want.status));
          if (out_tdata[47:0] !== want.sector)
            flag_field("sector", 64'(out_tdata[47:0]), 64'(want.sector));
          if (out_tdata[63:48] !== want.length)
            flag_field("length", 64'(out_tdata[63:48]), 64'(want.length));
          if (out_tdata[71:64] !== want.tag)
            flag_field("tag", 64'(out_tdata[71:64]), 64'(want.tag));
          if (out_tdata[72] !== want.fwd)
            flag_field("sweep_forward", 64'(out_tdata[72]), 64'(want.fwd));
          if (out_tdata[78:73] !== want.count)
            flag_field("pending_count", 64'(out_tdata[78:73]), 64'(want.count));
          if (out_tdata[79] !== 1'b0)
            flag_field("pad bit", 64'(out_tdata[79]), 64'h0);
        end
      end
    end
    results_owed <= dispatch_q.size();
  end

endmodule

### tb/look_elevator_request_scheduler_top_tb.sv
`timescale 1ns / 1ps
// Top of the LOOK request scheduler testbench: clock, reset, request stimulus,
// receiver back-pressure and the verdict; checking lives in the scheduler checker.
module look_elevator_request_scheduler_top_tb;
  import lers_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [SECTOR_FIELD_W-1:0] TOP_SECTOR = '1;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = ACT_ADD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  int mismatch_count;
  int results_owed;
  int full_hits;
  int empty_hits;

  int send_idle_pct = 10;
  int rcv_idle_pct  = 47;
  int cycle_count   = 0;
  int adds_sent     = 0;
  int dispatches_sent = 0;
  logic [SECTOR_FIELD_W-1:0] last_sector = '0;

  look_elevator_request_scheduler_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  look_elevator_request_scheduler_checker sched_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed),
    .full_hits      (full_hits),
    .empty_hits     (empty_hits)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure: drop tready on a random share of cycles.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, results_owed);
      $display("look_elevator_request_scheduler_top: mismatch");
      $finish;
    end
  end

  // Present one transaction and hold it until accepted. Valid stays high on
  // return so back-to-back items never lower and raise it in the same step.
  task automatic send_item(input logic act, input logic [SECTOR_FIELD_W-1:0] sec,
                           input logic [LENGTH_W-1:0] len, input logic [TAG_W-1:0] tag);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      // long or short gap, so idling lands on every phase of the block's work
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {tag, len, sec};
    do @(posedge clk); while (!in_tready);
    if (act == ACT_ADD) adds_sent++;
    else dispatches_sent++;
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Sectors: often a narrow cluster near the low end so equal sectors and
  // requests at the head come up often, plus full-range and edge values.
  function automatic logic [SECTOR_FIELD_W-1:0] pick_sector();
    logic [SECTOR_FIELD_W-1:0] s;
    case ($urandom_range(11))
      0, 1, 2, 3: s = SECTOR_FIELD_W'($urandom_range(0, 40));
      4:          s = last_sector;
      5:          s = 48'h0000_1000_0000 + SECTOR_FIELD_W'($urandom_range(0, 200));
      6:          s = TOP_SECTOR - SECTOR_FIELD_W'($urandom_range(0, 300));
      7:          s = ($urandom_range(1) == 0) ? '0 : TOP_SECTOR;
      default:    s = SECTOR_FIELD_W'({$urandom, $urandom});
    endcase
    return s;
  endfunction

  function automatic logic [LENGTH_W-1:0] pick_length();
    logic [LENGTH_W-1:0] l;
    case ($urandom_range(7))
      0:       l = '1;
      1, 2:    l = LENGTH_W'($urandom);
      default: l = LENGTH_W'($urandom_range(0, 12));
    endcase
    return l;
  endfunction

  // Random traffic in bursts: fill bursts push the store to full, drain bursts
  // empty it, mixed bursts keep the sweep turning with a partly filled store.
  task automatic random_phase(input int item_target);
    int sent;
    int burst_len;
    int add_pct;
    int k;
    logic [SECTOR_FIELD_W-1:0] sec;
    sent = 0;
    while (sent < item_target) begin
      case ($urandom_range(2))
        0:       add_pct = 85;
        1:       add_pct = 15;
        default: add_pct = 50;
      endcase
      burst_len = $urandom_range(10, 60);
      for (k = 0; k < burst_len && sent < item_target; k++) begin
        sec = pick_sector();
        if ($urandom_range(99) < add_pct) begin
          last_sector = sec;
          send_item(ACT_ADD, sec, pick_length(), TAG_W'($urandom));
        end else begin
          // dispatch carries noise in tdata; the block must ignore it
          send_item(ACT_DISPATCH, sec, LENGTH_W'($urandom), TAG_W'($urandom));
        end
        sent++;
      end
      if ($urandom_range(7) == 0) hold_until_drained();
    end
    hold_until_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty store, lone request, head saturation, equal
    // sectors in both directions, a request sitting at the head, turns.
    send_item(ACT_DISPATCH, TOP_SECTOR, 16'hFFFF, 8'hFF);
    send_item(ACT_ADD, 48'd100, 16'd5, 8'h00);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_ADD, TOP_SECTOR, 16'hFFFF, 8'hFF);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_ADD, 48'd0, 16'd0, 8'h01);
    send_item(ACT_ADD, 48'd0, 16'd0, 8'h02);
    send_item(ACT_ADD, 48'd50, 16'd0, 8'h03);
    send_item(ACT_ADD, 48'd50, 16'd0, 8'h04);
    send_item(ACT_ADD, 48'd50, 16'd0, 8'h05);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_ADD, 48'd0, 16'd0, 8'h06);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_ADD, 48'd50, 16'hFFFF, 8'h07);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_DISPATCH, '0, '0, '0);
    send_item(ACT_ADD, 48'h8000_0000_0000, 16'h8000, 8'hAA);
    send_item(ACT_DISPATCH, 48'h5555_5555_5555, 16'h5555, 8'h55);
    hold_until_drained();

    // Phase 1: sender idles a little, receiver stalls often.
    random_phase(615);
    // Phase 2: swap the idle shares.
    send_idle_pct = 47;
    rcv_idle_pct  = 10;
    random_phase(615);
    // Phase 3: full rate on both sides.
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    random_phase(620);

    // Drain, then allow a dispatch-sized latency for stray results.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (100) @(posedge clk);

    $display("covered %0d adds and %0d dispatches under three back-pressure mixes",
             adds_sent, dispatches_sent);
    $display("store found full %0d times and empty %0d times", full_hits, empty_hits);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("look_elevator_request_scheduler_top: match");
    end else begin
      $display("look_elevator_request_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule
